// ===== design/vcrd_pkg.sv =====
// Shared definitions for the vector clock race detector.
// Holds field widths, command and status codes and parameter defaults.
// No dependencies.
`default_nettype none
package vcrd_pkg;

  localparam int unsigned COMMAND_W = 3;
  localparam int unsigned THREAD_W  = 3;
  localparam int unsigned TARGET_W  = 8;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned THREADS_DEF    = 8;
  localparam int unsigned LOCKS_DEF      = 16;
  localparam int unsigned VARIABLES_DEF  = 256;
  localparam int unsigned CLOCK_BITS_DEF = 32;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_ACQUIRE = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_FORK    = 3'd4,
    CMD_JOIN    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_WR_RACE = 2'd1,
    ST_WW_RACE = 2'd2,
    ST_RW_RACE = 2'd3
  } status_e;

endpackage
`default_nettype wire

// ===== design/vcrd_intf.sv =====
// Event and result channel interfaces of the vector clock race detector.
// Depends on vcrd_pkg for the field widths.
`default_nettype none
interface vcrd_evt_if;
  logic                           valid;
  logic                           ready;
  logic [vcrd_pkg::COMMAND_W-1:0] command;
  logic [vcrd_pkg::THREAD_W-1:0]  thread_index;
  logic [vcrd_pkg::TARGET_W-1:0]  target_index;

  modport source(output valid, output command, output thread_index,
                 output target_index, input ready);
  modport sink(input valid, input command, input thread_index,
               input target_index, output ready);
endinterface

interface vcrd_res_if;
  logic                          valid;
  logic                          ready;
  logic [vcrd_pkg::STATUS_W-1:0] status;

  modport source(output valid, output status, input ready);
  modport sink(input valid, input status, output ready);
endinterface
`default_nettype wire

// ===== design/vector_clock_race_detector.sv =====
// FastTrack style data race detector: vector clocks, epochs and a sequencer.
// Depends on vcrd_pkg and the channel interfaces in vcrd_intf.sv.
//
// After reset the block runs a clearing pass through its clock memories and
// accepts no event meanwhile. Then it takes one event at a time and returns
// one status beat per event. The vector work of a write to a shared variable,
// an acquire, a release, a fork or a join walks one clock entry per cycle
// through the single compare and max unit, on two read ports of the thread
// clock memory and one of each other clock memory. An event that is ignored
// returns ok. A new event is accepted while an earlier status beat still
// waits to be taken.
`default_nettype none
module vector_clock_race_detector #(
  parameter int unsigned THREADS    = vcrd_pkg::THREADS_DEF,
  parameter int unsigned LOCKS      = vcrd_pkg::LOCKS_DEF,
  parameter int unsigned VARIABLES  = vcrd_pkg::VARIABLES_DEF,
  parameter int unsigned CLOCK_BITS = vcrd_pkg::CLOCK_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vcrd_evt_if.sink   evt_i,
  vcrd_res_if.source res_o
);

  localparam int unsigned CB   = CLOCK_BITS;
  localparam int unsigned TW   = $clog2(THREADS);
  localparam int unsigned LW   = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int unsigned VW   = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;
  localparam int unsigned TMD  = THREADS * THREADS;
  localparam int unsigned TAW  = $clog2(TMD);
  localparam int unsigned LMD  = LOCKS * THREADS;
  localparam int unsigned LAW  = $clog2(LMD);
  localparam int unsigned RMD  = VARIABLES * THREADS;
  localparam int unsigned RAW  = $clog2(RMD);
  localparam int unsigned CLR0 = (TMD > LMD) ? TMD : LMD;
  localparam int unsigned CLR  = (CLR0 > RMD) ? CLR0 : RMD;
  localparam int unsigned CW   = $clog2(CLR + 1);
  localparam int unsigned IW   = $clog2(THREADS + 1);

  typedef struct packed {
    logic          sh;
    logic [TW-1:0] wt;
    logic [CB-1:0] wc;
    logic [TW-1:0] rt;
    logic [CB-1:0] rc;
  } meta_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_START, S_VA, S_VB, S_VC, S_VD, S_SCAN, S_TK0, S_TK1, S_DONE
  } state_e;

  function automatic logic [TAW-1:0] taddr(input logic [TW-1:0] r,
                                           input logic [TW-1:0] c);
    return TAW'(int'(r) * THREADS + int'(c));
  endfunction

  function automatic logic [LAW-1:0] laddr(input logic [LW-1:0] r,
                                           input logic [TW-1:0] c);
    return LAW'(int'(r) * THREADS + int'(c));
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [VW-1:0] r,
                                           input logic [TW-1:0] c);
    return RAW'(int'(r) * THREADS + int'(c));
  endfunction

  // Memories.
  logic [CB-1:0] tmem [TMD];
  logic [CB-1:0] lmem [LMD];
  logic [CB-1:0] rmem [RMD];
  meta_t         mmem [VARIABLES];

  logic [CB-1:0]  ta_rd, tb_rd, l_rd, r_rd;
  meta_t          md_rd;
  logic [TAW-1:0] ta_a, tb_a, t_wa;
  logic [LAW-1:0] l_a, l_wa;
  logic [RAW-1:0] r_a, r_wa;
  logic [VW-1:0]  m_a;
  logic [CB-1:0]  t_wd, l_wd, r_wd;
  meta_t          m_wd;
  logic           t_we, l_we, r_we, m_we;

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[t_wa] <= t_wd;
    end
    ta_rd <= tmem[ta_a];
    tb_rd <= tmem[tb_a];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      lmem[l_wa] <= l_wd;
    end
    l_rd <= lmem[l_a];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rmem[r_wa] <= r_wd;
    end
    r_rd <= rmem[r_a];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mmem[m_a] <= m_wd;
    end
    md_rd <= mmem[m_a];
  end

  // Control and item registers.
  state_e                        state_q;
  logic [CW-1:0]                 clr_q, dg_q;
  logic [vcrd_pkg::COMMAND_W-1:0] cmd_q;
  logic [vcrd_pkg::THREAD_W-1:0]  thr_q;
  logic [vcrd_pkg::TARGET_W-1:0]  tgt_q;
  logic [CB-1:0]                 now_q, ctw_q, rcv_q;
  meta_t                         meta_q;
  logic [IW-1:0]                 idx_q;
  logic [TW-1:0]                 cidx_q;
  logic                          cmpv_q;
  vcrd_pkg::status_e             st_q, res_st_q;
  logic                          res_valid_q;

  logic [TW-1:0] tsel, xt, col, tk;
  logic [LW-1:0] xl;
  logic [VW-1:0] xv;
  logic          item_ok, issue;
  logic          hit_rd, sh_hit, wr_bad, rd_bad, hit_wr, scan_race;
  logic [CB-1:0] dst, src, mx;
  meta_t         upd;

  assign tsel = TW'(thr_q);
  assign xt   = TW'(tgt_q);
  assign xl   = LW'(tgt_q);
  assign xv   = VW'(tgt_q);
  assign col  = idx_q[TW-1:0];
  assign issue = int'(idx_q) < THREADS;
  assign tk   = (vcrd_pkg::cmd_e'(cmd_q) == vcrd_pkg::CMD_JOIN) ? xt : tsel;

  always_comb begin
    item_ok = 1'b0;
    case (vcrd_pkg::cmd_e'(cmd_q))
      vcrd_pkg::CMD_READ, vcrd_pkg::CMD_WRITE: item_ok = int'(tgt_q) < VARIABLES;
      vcrd_pkg::CMD_ACQUIRE, vcrd_pkg::CMD_RELEASE: item_ok = int'(tgt_q) < LOCKS;
      vcrd_pkg::CMD_FORK, vcrd_pkg::CMD_JOIN: item_ok = int'(tgt_q) < THREADS;
      default: item_ok = 1'b0;
    endcase
    item_ok = item_ok && (int'(thr_q) < THREADS);
  end

  // Epoch checks; ta_rd holds the thread clock at the read epoch's thread in S_VC.
  assign hit_rd    = (meta_q.rt == tsel) && (meta_q.rc == now_q);
  assign sh_hit    = meta_q.sh && (rcv_q == now_q);
  assign wr_bad    = meta_q.wc > ctw_q;
  assign rd_bad    = meta_q.rc > ta_rd;
  assign hit_wr    = (meta_q.wt == tsel) && (meta_q.wc == now_q);
  assign scan_race = cmpv_q && (r_rd > ta_rd);

  // Shared max unit: destination and source by command.
  always_comb begin
    dst = ta_rd;
    src = l_rd;
    case (vcrd_pkg::cmd_e'(cmd_q))
      vcrd_pkg::CMD_RELEASE: begin
        dst = l_rd;
        src = ta_rd;
      end
      vcrd_pkg::CMD_FORK: begin
        dst = tb_rd;
        src = ta_rd;
      end
      vcrd_pkg::CMD_JOIN: begin
        dst = ta_rd;
        src = tb_rd;
      end
      default: begin
        dst = ta_rd;
        src = l_rd;
      end
    endcase
    mx = (src > dst) ? src : dst;
  end

  always_comb begin
    ta_a = taddr(tsel, tsel);
    tb_a = taddr(xt, col);
    l_a  = laddr(xl, col);
    r_a  = raddr(xv, col);
    m_a  = xv;
    t_we = 1'b0;
    t_wa = taddr(tsel, cidx_q);
    t_wd = mx;
    l_we = 1'b0;
    l_wa = laddr(xl, cidx_q);
    l_wd = mx;
    r_we = 1'b0;
    r_wa = raddr(xv, tsel);
    r_wd = now_q;
    m_we = 1'b0;
    upd  = meta_q;
    m_wd = meta_q;
    case (state_q)
      S_CLR: begin
        t_we = int'(clr_q) < TMD;
        t_wa = clr_q[TAW-1:0];
        t_wd = (clr_q == dg_q) ? CB'(1) : '0;
        l_we = int'(clr_q) < LMD;
        l_wa = clr_q[LAW-1:0];
        l_wd = '0;
        r_we = int'(clr_q) < RMD;
        r_wa = clr_q[RAW-1:0];
        r_wd = '0;
        m_we = int'(clr_q) < VARIABLES;
        m_a  = clr_q[VW-1:0];
        m_wd = '0;
      end
      S_VA: begin
        ta_a = taddr(tsel, md_rd.wt);
        r_a  = raddr(xv, tsel);
      end
      S_VB: begin
        ta_a = taddr(tsel, meta_q.rt);
      end
      S_VC: begin
        if (vcrd_pkg::cmd_e'(cmd_q) == vcrd_pkg::CMD_READ) begin
          if (!hit_rd && !sh_hit && !wr_bad) begin
            if (meta_q.sh) begin
              r_we = 1'b1;
            end else if (!rd_bad) begin
              upd.rt = tsel;
              upd.rc = now_q;
              m_we   = 1'b1;
              m_wd   = upd;
            end else begin
              r_we   = 1'b1;
              r_wa   = raddr(xv, meta_q.rt);
              r_wd   = meta_q.rc;
              upd.sh = 1'b1;
              m_we   = 1'b1;
              m_wd   = upd;
            end
          end
        end else if (!hit_wr && !wr_bad && !meta_q.sh && !rd_bad) begin
          upd.wt = tsel;
          upd.wc = now_q;
          m_we   = 1'b1;
          m_wd   = upd;
        end
      end
      S_VD: begin
        r_we = 1'b1;
      end
      S_SCAN: begin
        ta_a = taddr(tsel, col);
        if (cmpv_q) begin
          case (vcrd_pkg::cmd_e'(cmd_q))
            vcrd_pkg::CMD_ACQUIRE, vcrd_pkg::CMD_JOIN: begin
              t_we = 1'b1;
            end
            vcrd_pkg::CMD_FORK: begin
              t_we = 1'b1;
              t_wa = taddr(xt, cidx_q);
            end
            vcrd_pkg::CMD_RELEASE: begin
              l_we = 1'b1;
            end
            default: begin
              t_we = 1'b0;
            end
          endcase
        end
        if (!issue && !cmpv_q && vcrd_pkg::cmd_e'(cmd_q) == vcrd_pkg::CMD_WRITE) begin
          upd.wt = tsel;
          upd.wc = now_q;
          m_we   = 1'b1;
          m_wd   = upd;
        end
      end
      S_TK0: begin
        ta_a = taddr(tk, tk);
      end
      S_TK1: begin
        t_we = 1'b1;
        t_wa = taddr(tk, tk);
        t_wd = (ta_rd == {CB{1'b1}}) ? ta_rd : ta_rd + CB'(1);
      end
      default: begin
        t_we = 1'b0;
      end
    endcase
  end

  assign evt_i.ready  = (state_q == S_IDLE);
  assign res_o.valid  = res_valid_q;
  assign res_o.status = res_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      dg_q        <= '0;
      idx_q       <= '0;
      cidx_q      <= '0;
      cmpv_q      <= 1'b0;
      st_q        <= vcrd_pkg::ST_OK;
      res_st_q    <= vcrd_pkg::ST_OK;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready && state_q != S_DONE) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == dg_q) begin
            dg_q <= dg_q + CW'(THREADS + 1);
          end
          if (clr_q == CW'(CLR - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (evt_i.valid) begin
            cmd_q   <= evt_i.command;
            thr_q   <= evt_i.thread_index;
            tgt_q   <= evt_i.target_index;
            state_q <= S_START;
          end
        end
        S_START: begin
          st_q   <= vcrd_pkg::ST_OK;
          idx_q  <= '0;
          cmpv_q <= 1'b0;
          if (!item_ok) begin
            state_q <= S_DONE;
          end else begin
            case (vcrd_pkg::cmd_e'(cmd_q))
              vcrd_pkg::CMD_READ, vcrd_pkg::CMD_WRITE: state_q <= S_VA;
              default: state_q <= S_SCAN;
            endcase
          end
        end
        S_VA: begin
          now_q   <= ta_rd;
          meta_q  <= md_rd;
          state_q <= S_VB;
        end
        S_VB: begin
          ctw_q   <= ta_rd;
          rcv_q   <= r_rd;
          state_q <= S_VC;
        end
        S_VC: begin
          state_q <= S_DONE;
          if (vcrd_pkg::cmd_e'(cmd_q) == vcrd_pkg::CMD_READ) begin
            if (hit_rd || sh_hit) begin
              st_q <= vcrd_pkg::ST_OK;
            end else if (wr_bad) begin
              st_q <= vcrd_pkg::ST_WR_RACE;
            end else if (!meta_q.sh && rd_bad) begin
              state_q <= S_VD;
            end
          end else begin
            if (hit_wr) begin
              st_q <= vcrd_pkg::ST_OK;
            end else if (wr_bad) begin
              st_q <= vcrd_pkg::ST_WW_RACE;
            end else if (!meta_q.sh) begin
              if (rd_bad) begin
                st_q <= vcrd_pkg::ST_RW_RACE;
              end
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_VD: begin
          state_q <= S_DONE;
        end
        S_SCAN: begin
          cmpv_q <= issue;
          cidx_q <= col;
          if (issue) begin
            idx_q <= idx_q + IW'(1);
          end
          if (vcrd_pkg::cmd_e'(cmd_q) == vcrd_pkg::CMD_WRITE && scan_race) begin
            st_q    <= vcrd_pkg::ST_RW_RACE;
            state_q <= S_DONE;
          end else if (!issue && !cmpv_q) begin
            case (vcrd_pkg::cmd_e'(cmd_q))
              vcrd_pkg::CMD_WRITE, vcrd_pkg::CMD_ACQUIRE: state_q <= S_DONE;
              default: state_q <= S_TK0;
            endcase
          end
        end
        S_TK0: begin
          state_q <= S_TK1;
        end
        S_TK1: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_st_q    <= st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/vcrd_checker.sv =====
// Port-level assertions for the vector clock race detector, bound to the top.
// Depends on vcrd_pkg for the field widths.
`default_nettype none
module vcrd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          evt_valid_i,
  input wire logic                          evt_ready_i,
  input wire logic                          res_valid_i,
  input wire logic                          res_ready_i,
  input wire logic [vcrd_pkg::STATUS_W-1:0] res_status_i
);

  // The block works on one event at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event accepted while an event is in progress");

  // A status beat never appears in the cycle right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !$rose(res_valid_i))
    else $error("status beat appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("status beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i))
    else $error("status changed while stalled");

endmodule

bind vector_clock_race_detector vcrd_checker u_vcrd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .evt_valid_i  (evt_i.valid),
  .evt_ready_i  (evt_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status)
);
`default_nettype wire
